>>> src/tcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_pkg
// Shared types and constants of the track collision pruning unit.
// ----------------------------------------------------------------------------
package tcp_pkg;

  localparam int COORD_W     = 16;
  localparam int LEN_W       = 16;
  localparam int ID_W        = 32;
  localparam int CFG_W       = 16;
  localparam int LIMIT_W     = 2 * CFG_W;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int IN_DATA_W   = 2 * COORD_W + LEN_W + ID_W;
  localparam int OUT_INDEX_W = 6;
  localparam int OUT_DATA_W  = OUT_INDEX_W + 2;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [LEN_W-1:0]   length;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } track_entry_t;

  // request into the distance unit
  typedef struct packed {
    logic valid;
    logic use_entry;
    logic last;
  } dist_req_t;

  // response from the distance unit
  typedef struct packed {
    logic valid;
    logic hit;
    logic last;
  } dist_rsp_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SELECT,
    ST_DECIDE,
    ST_CHECK,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

>>> src/tcp_track_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_track_store
// Track memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcp_track_store #(
  parameter int DEPTH = 64
) (
  input  wire                        clk,
  input  wire                        wr_en,
  input  wire  [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire  tcp_pkg::track_entry_t wr_data,
  input  wire                        rd_en,
  input  wire  [$clog2(DEPTH)-1:0]   rd_addr,
  output tcp_pkg::track_entry_t      rd_data
);

  tcp_pkg::track_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> src/tcp_dist_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_dist_unit
// Shared squared distance unit: three stages, absolute differences, squares,
// then sum and compare against the squared collision distance.
// ----------------------------------------------------------------------------
module tcp_dist_unit (
  input  wire                              clk,
  input  wire                              rst,
  input  wire  [tcp_pkg::CFG_W-1:0]        sep_radius,
  input  wire  [tcp_pkg::COORD_W-1:0]      cur_x,
  input  wire  [tcp_pkg::COORD_W-1:0]      cur_y,
  input  wire  [tcp_pkg::COORD_W-1:0]      ent_x,
  input  wire  [tcp_pkg::COORD_W-1:0]      ent_y,
  input  wire  tcp_pkg::dist_req_t         req,
  output tcp_pkg::dist_rsp_t               rsp
);

  logic [tcp_pkg::LIMIT_W-1:0] limit;
  logic [tcp_pkg::COORD_W-1:0] dx;
  logic [tcp_pkg::COORD_W-1:0] dy;
  logic [tcp_pkg::SQ_W-1:0]    dx_sq;
  logic [tcp_pkg::SQ_W-1:0]    dy_sq;
  logic [tcp_pkg::SQ_W:0]      sum_sq;
  tcp_pkg::dist_req_t          s1;
  tcp_pkg::dist_req_t          s2;

  // squared limit, refreshed every cycle from the register
  always_ff @(posedge clk) begin
    limit <= tcp_pkg::LIMIT_W'(sep_radius) * tcp_pkg::LIMIT_W'(sep_radius);
  end

  always_ff @(posedge clk) begin
    dx    <= (cur_x > ent_x) ? cur_x - ent_x : ent_x - cur_x;
    dy    <= (cur_y > ent_y) ? cur_y - ent_y : ent_y - cur_y;
    dx_sq <= tcp_pkg::SQ_W'(dx) * tcp_pkg::SQ_W'(dx);
    dy_sq <= tcp_pkg::SQ_W'(dy) * tcp_pkg::SQ_W'(dy);
  end

  assign sum_sq = {1'b0, dx_sq} + {1'b0, dy_sq};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1  <= '0;
      s2  <= '0;
      rsp <= '0;
    end else begin
      s1        <= req;
      s2        <= s1;
      rsp.valid <= s2.valid;
      rsp.last  <= s2.valid & s2.last;
      rsp.hit   <= s2.valid & s2.use_entry & (sum_sq < {1'b0, limit});
    end
  end

endmodule
`default_nettype wire

>>> src/track_collision_pruning_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// track_collision_pruning_unit
// Greedy radius non-maximum suppression over a set of loaded tracks.
// ----------------------------------------------------------------------------
// Tracks load one per cycle. The request with tlast starts the pass: the
// sequencer repeatedly scans the track memory (one entry a cycle through its
// single read port) to pick the best unprocessed active track, then scans it
// again through the shared three-stage distance unit against every kept
// track. When no unprocessed active track is left, the unit emits one
// result per loaded track in load order, each with its drop flag.
// ----------------------------------------------------------------------------
module track_collision_pruning_unit #(
  parameter int MAX_TRACKS = 64
) (
  input  wire                                clk,
  input  wire                                rst,
  // configuration: collision distance, unsigned Q12.4
  input  wire                                cfg_wr_en,
  input  wire  [tcp_pkg::CFG_W-1:0]          cfg_wr_data,
  // tdata: track_x[15:0], track_y[31:16], track_length[47:32], ident[79:48]
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [tcp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: track_active[0]
  input  wire                                s_axis_tuser,
  input  wire                                s_axis_tlast,
  // tdata: track_index[5:0], drop[6], overflow[7]
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [tcp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tlast
);

  localparam int IDX_W = $clog2(MAX_TRACKS);
  localparam int CNT_W = $clog2(MAX_TRACKS + 1);

  tcp_pkg::state_t state;
  tcp_pkg::state_t state_next;

  logic [tcp_pkg::CFG_W-1:0]   sep_radius;
  logic [CNT_W-1:0]            load_count;
  logic [CNT_W-1:0]            last_pos;
  logic                        overflow_seen;
  logic [MAX_TRACKS-1:0]       active_flags;
  logic [MAX_TRACKS-1:0]       kept_flags;
  logic [MAX_TRACKS-1:0]       dropped_flags;

  logic [CNT_W-1:0]            rd_ptr;
  logic                        rd_en;
  logic                        rd_vld;
  logic [IDX_W-1:0]            rd_tag;
  logic                        rd_is_last;
  tcp_pkg::track_entry_t       rd_data;

  logic                        best_found;
  logic [IDX_W-1:0]            best_idx;
  logic [tcp_pkg::LEN_W-1:0]   best_len;
  logic [tcp_pkg::ID_W-1:0]    best_id;
  logic [tcp_pkg::COORD_W-1:0] cur_x;
  logic [tcp_pkg::COORD_W-1:0] cur_y;
  logic                        hit_acc;
  logic [IDX_W-1:0]            emit_idx;

  logic                        in_fire;
  logic                        out_fire;
  logic                        store_wr;
  logic                        eligible;
  logic                        better;
  logic                        sel_done;
  logic                        chk_done;
  logic                        hit_any;

  tcp_pkg::track_entry_t       wr_entry;
  tcp_pkg::dist_req_t          dreq;
  tcp_pkg::dist_rsp_t          drsp;

  assign in_fire    = s_axis_tvalid & s_axis_tready;
  assign out_fire   = m_axis_tvalid & m_axis_tready;
  assign store_wr   = in_fire & (load_count < CNT_W'(MAX_TRACKS));
  assign last_pos   = load_count - CNT_W'(1);
  assign rd_en      = ((state == tcp_pkg::ST_SELECT) || (state == tcp_pkg::ST_CHECK))
                      && (rd_ptr < load_count);
  assign rd_is_last = (CNT_W'(rd_tag) == last_pos);

  assign wr_entry.x      = s_axis_tdata[15:0];
  assign wr_entry.y      = s_axis_tdata[31:16];
  assign wr_entry.length = s_axis_tdata[47:32];
  assign wr_entry.id     = s_axis_tdata[79:48];

  assign eligible = rd_vld & active_flags[rd_tag] & ~kept_flags[rd_tag] & ~dropped_flags[rd_tag];
  assign better   = ~best_found || (rd_data.length > best_len) ||
                    ((rd_data.length == best_len) && (rd_data.id < best_id));
  assign sel_done = (state == tcp_pkg::ST_SELECT) & rd_vld & rd_is_last;
  assign chk_done = (state == tcp_pkg::ST_CHECK) & drsp.valid & drsp.last;
  assign hit_any  = hit_acc | drsp.hit;

  assign dreq.valid     = rd_vld & (state == tcp_pkg::ST_CHECK);
  assign dreq.use_entry = kept_flags[rd_tag];
  assign dreq.last      = rd_is_last;

  tcp_track_store #(
    .DEPTH (MAX_TRACKS)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (load_count[IDX_W-1:0]),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  tcp_dist_unit u_dist (
    .clk        (clk),
    .rst        (rst),
    .sep_radius (sep_radius),
    .cur_x      (cur_x),
    .cur_y      (cur_y),
    .ent_x      (rd_data.x),
    .ent_y      (rd_data.y),
    .req        (dreq),
    .rsp        (drsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcp_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state)
      tcp_pkg::ST_LOAD: begin
        s_axis_tready = 1'b1;
        if (in_fire && s_axis_tlast) begin
          state_next = tcp_pkg::ST_SELECT;
        end
      end
      tcp_pkg::ST_SELECT: begin
        if (sel_done) begin
          state_next = tcp_pkg::ST_DECIDE;
        end
      end
      tcp_pkg::ST_DECIDE: begin
        state_next = best_found ? tcp_pkg::ST_CHECK : tcp_pkg::ST_EMIT;
      end
      tcp_pkg::ST_CHECK: begin
        if (chk_done) begin
          state_next = tcp_pkg::ST_SELECT;
        end
      end
      tcp_pkg::ST_EMIT: begin
        m_axis_tvalid = 1'b1;
        if (out_fire && m_axis_tlast) begin
          state_next = tcp_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = tcp_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_radius <= '0;
    end else if (cfg_wr_en) begin
      sep_radius <= cfg_wr_data;
    end
  end

  // loader and per-set flags
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count    <= '0;
      overflow_seen <= 1'b0;
      active_flags  <= '0;
      kept_flags    <= '0;
      dropped_flags <= '0;
    end else begin
      if (store_wr) begin
        load_count                         <= load_count + CNT_W'(1);
        active_flags[load_count[IDX_W-1:0]] <= s_axis_tuser;
      end else if (in_fire) begin
        overflow_seen <= 1'b1;
      end
      if (in_fire && s_axis_tlast) begin
        kept_flags    <= '0;
        dropped_flags <= '0;
      end
      if (chk_done) begin
        if (hit_any) begin
          dropped_flags[best_idx] <= 1'b1;
        end else begin
          kept_flags[best_idx] <= 1'b1;
        end
      end
      // clear the loader once the final result is taken
      if (out_fire && m_axis_tlast) begin
        load_count    <= '0;
        overflow_seen <= 1'b0;
        active_flags  <= '0;
      end
    end
  end

  // read sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if (rd_en) begin
        rd_ptr <= rd_ptr + CNT_W'(1);
      end
      if ((state == tcp_pkg::ST_LOAD) || (state == tcp_pkg::ST_DECIDE) || chk_done) begin
        rd_ptr <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_tag <= rd_ptr[IDX_W-1:0];
  end

  // best candidate and hit accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
      hit_acc    <= 1'b0;
      emit_idx   <= '0;
    end else begin
      if (state == tcp_pkg::ST_SELECT && eligible && better) begin
        best_found <= 1'b1;
      end
      if (state == tcp_pkg::ST_DECIDE) begin
        hit_acc  <= 1'b0;
        emit_idx <= '0;
      end
      if (state == tcp_pkg::ST_CHECK && drsp.valid) begin
        hit_acc <= hit_any;
      end
      if (chk_done) begin
        best_found <= 1'b0;
      end
      if (out_fire) begin
        emit_idx <= emit_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == tcp_pkg::ST_SELECT && eligible && better) begin
      best_idx <= rd_tag;
      best_len <= rd_data.length;
      best_id  <= rd_data.id;
      cur_x    <= rd_data.x;
      cur_y    <= rd_data.y;
    end
  end

  assign m_axis_tdata = {overflow_seen, dropped_flags[emit_idx],
                         tcp_pkg::OUT_INDEX_W'(emit_idx)};
  assign m_axis_tlast = (CNT_W'(emit_idx) == last_pos);

  a_no_double_mark: assert property (@(posedge clk) disable iff (rst)
    (kept_flags & dropped_flags) == '0)
    else $error("track both kept and dropped");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    load_count <= CNT_W'(MAX_TRACKS))
    else $error("load count beyond capacity");

  a_check_end_state: assert property (@(posedge clk) disable iff (rst)
    (drsp.valid && drsp.last) |-> (state == tcp_pkg::ST_CHECK))
    else $error("distance response outside check scan");

  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_fire && m_axis_tlast) |=> (load_count == '0 && !overflow_seen && active_flags == '0))
    else $error("loader not cleared after final result");

  a_marked_active: assert property (@(posedge clk) disable iff (rst)
    chk_done |-> active_flags[best_idx])
    else $error("inactive track ranked");

endmodule
`default_nettype wire
